// ----- src/spq_pkg.sv -----
// Shared types and constants for the sorted priority queue.
package spq_pkg;

	localparam int SPQ_DEPTH = 16;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_POP    = 1'b1;

	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_POPPED   = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	typedef struct packed {
		logic        cmd;
		logic [15:0] entry_id;
		logic [7:0]  priority_req;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] out_id;
		logic [7:0]  out_priority;
		logic [4:0]  occupancy;
	} rsp_t;

	typedef struct packed {
		logic [15:0] id;
		logic [7:0]  prio;
	} entry_t;

	// broadcast to every cell in the chain
	typedef struct packed {
		logic   ins;
		logic   pop;
		entry_t ent;
	} cell_ctl_t;

endpackage

// ----- src/spq_cell.sv -----
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
module spq_cell #(
	parameter int IDX = 0,
	parameter int CW  = 5
) (
	input  logic               clk,
	input  spq_pkg::cell_ctl_t ctl,
	input  logic [CW-1:0]      count,
	input  logic               left_ge,
	input  spq_pkg::entry_t    left_ent,
	input  spq_pkg::entry_t    right_ent,
	output spq_pkg::entry_t    ent,
	output logic               ge
);
	import spq_pkg::*;

	entry_t ent_q;
	logic   occ;

	assign occ = count > CW'(IDX);
	// stored entry stays ahead of the new one when its priority is equal or higher
	assign ge  = occ && (ent_q.prio >= ctl.ent.prio);
	assign ent = ent_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (!ge) begin
				if (left_ge || (IDX == 0)) begin
					ent_q <= ctl.ent;
				end else begin
					ent_q <= left_ent;
				end
			end
		end else if (ctl.pop) begin
			ent_q <= right_ent;
		end
	end

endmodule

// ----- src/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: cell chain, fill count and result register.
// Bounded priority queue of DEPTH entries held in a chain of cells sorted by
// descending priority, front at cell 0. An insert word lands behind every entry
// of equal or higher priority (equal priorities leave in arrival order); a pop
// word returns the front entry. Each request word yields one response word with
// the status and the occupancy after the operation. Every cell compares its own
// priority with the incoming one and all cells shift together, so one request
// is accepted per cycle while the response register can drain; the response
// register is the only thing that holds off a request.
module sorted_priority_queue #(
	parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  spq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output spq_pkg::rsp_t rsp
);
	import spq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0] count_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;
	cell_ctl_t     ctl;
	entry_t        ents  [DEPTH];
	logic          ges   [DEPTH];
	logic          accept;
	logic          full;
	logic          empty;
	logic [CW-1:0] count_next;
	logic [CW+4:0] count_ext;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign full      = count_q == CW'(DEPTH);
	assign empty     = count_q == '0;

	assign ctl.ins      = accept && (req.cmd == CMD_INSERT) && !full;
	assign ctl.pop      = accept && (req.cmd == CMD_POP) && !empty;
	assign ctl.ent.id   = req.entry_id;
	assign ctl.ent.prio = req.priority_req;

	always_comb begin
		count_next = count_q;
		if (ctl.ins) begin
			count_next = count_q + CW'(1);
		end else if (ctl.pop) begin
			count_next = count_q - CW'(1);
		end
	end

	assign count_ext = {5'd0, count_next};

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			entry_t left_ent;
			entry_t right_ent;
			logic   left_ge;
			if (g == 0) begin : g_first
				assign left_ent = '0;
				assign left_ge  = 1'b0;
			end else begin : g_mid
				assign left_ent = ents[g-1];
				assign left_ge  = ges[g-1];
			end
			if (g == DEPTH - 1) begin : g_last
				assign right_ent = '0;
			end else begin : g_inner
				assign right_ent = ents[g+1];
			end
			spq_cell #(
				.IDX (g),
				.CW  (CW)
			) u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.count     (count_q),
				.left_ge   (left_ge),
				.left_ent  (left_ent),
				.right_ent (right_ent),
				.ent       (ents[g]),
				.ge        (ges[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.occupancy <= count_ext[4:0];
			if (req.cmd == CMD_INSERT) begin
				rsp_q.status       <= full ? ST_FULL : ST_INSERTED;
				rsp_q.out_id       <= '0;
				rsp_q.out_priority <= '0;
			end else if (empty) begin
				rsp_q.status       <= ST_EMPTY;
				rsp_q.out_id       <= '0;
				rsp_q.out_priority <= '0;
			end else begin
				rsp_q.status       <= ST_POPPED;
				rsp_q.out_id       <= ents[0].id;
				rsp_q.out_priority <= ents[0].prio;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count exceeds depth");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the fill count");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_ready |=> rsp_valid_q && $stable(rsp_q))
		else $error("stalled response word changed");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |-> !full && !ctl.pop)
		else $error("insert issued into full queue");

	generate
		for (g = 1; g < DEPTH; g++) begin : g_sort_chk
			a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
				count_q > CW'(g) |-> ents[g-1].prio >= ents[g].prio)
				else $error("chain out of priority order");
		end
	endgenerate

endmodule

// ----- dv/tb_sorted_priority_queue.sv -----
// Testbench for sorted_priority_queue: random traffic checked against a shadow sorted queue.
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
	import spq_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	req_t req_backlog [$];
	rsp_t rsp_due [$];
	entry_t shadow_slot [SPQ_DEPTH];
	int shadow_fill = 0;
	int errors = 0;
	int cycles = 0;
	int idle_pct = 0;
	int send_gap = 0;
	int stall_left = 0;
	logic req_took = 1'b0;

	sorted_priority_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	// Apply one request word to the shadow queue and return the response it should give.
	function automatic rsp_t serve_request(input req_t r);
		rsp_t res;
		int pos;
		res = '0;
		if (r.cmd == CMD_INSERT) begin
			if (shadow_fill >= SPQ_DEPTH) begin
				res.status = ST_FULL;
			end else begin
				// shift lower priorities back; equal ones stay ahead
				pos = shadow_fill;
				while (pos > 0 && shadow_slot[pos - 1].prio < r.priority_req) begin
					shadow_slot[pos] = shadow_slot[pos - 1];
					pos--;
				end
				shadow_slot[pos].id = r.entry_id;
				shadow_slot[pos].prio = r.priority_req;
				shadow_fill++;
				res.status = ST_INSERTED;
			end
		end else if (shadow_fill == 0) begin
			res.status = ST_EMPTY;
		end else begin
			res.status = ST_POPPED;
			res.out_id = shadow_slot[0].id;
			res.out_priority = shadow_slot[0].prio;
			for (int k = 0; k + 1 < shadow_fill; k++)
				shadow_slot[k] = shadow_slot[k + 1];
			shadow_fill--;
		end
		res.occupancy = 5'(shadow_fill);
		return res;
	endfunction

	function automatic void add_req(input logic c, input logic [15:0] id, input logic [7:0] p);
		req_t r;
		r.cmd = c;
		r.entry_id = id;
		r.priority_req = p;
		req_backlog.push_back(r);
	endfunction

	// Bursts that lean toward filling, draining or neither, with ties made common.
	task automatic queue_traffic(input int count);
		int left;
		int burst;
		int pop_pct;
		int spread;
		logic [7:0] p;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(40, 8);
			case ($urandom_range(2))
				0: pop_pct = 25;
				1: pop_pct = 50;
				default: pop_pct = 75;
			endcase
			spread = $urandom_range(2);
			repeat (burst) begin
				case (spread)
					0: p = 8'($urandom_range(3));
					1: p = 8'($urandom);
					default: p = ($urandom_range(1) != 0) ? 8'hFF : 8'($urandom_range(136, 120));
				endcase
				add_req(($urandom_range(99) < pop_pct) ? CMD_POP : CMD_INSERT,
					16'($urandom), p);
			end
			left -= burst;
		end
	endtask

	// Hold the sender until every queued word is in and every response is back.
	task automatic settle();
		while (req_backlog.size() != 0 || req_valid || rsp_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(negedge clk) begin : drive_req
		logic send;
		if (arst_n && !(req_valid && !req_took)) begin
			send = 1'b0;
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
			end else if (req_backlog.size() != 0) begin
				if ($urandom_range(99) < idle_pct) begin
					send_gap <= $urandom_range(6);
				end else begin
					send = 1'b1;
					req <= req_backlog.pop_front();
				end
			end
			req_valid <= send;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				rsp_ready <= 1'b0;
			end else if ($urandom_range(99) < idle_pct) begin
				stall_left <= $urandom_range(6);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : watch
		rsp_t want;
		if (arst_n) begin
			req_took <= req_valid && req_ready;
			if (rsp_valid && rsp_ready) begin
				if (rsp_due.size() == 0) begin
					$display("%0t: unexpected word status=%0d id=%h prio=%h occ=%0d",
						$time, rsp.status, rsp.out_id, rsp.out_priority, rsp.occupancy);
					errors++;
				end else begin
					want = rsp_due.pop_front();
					if (rsp.status !== want.status || rsp.out_id !== want.out_id ||
						rsp.out_priority !== want.out_priority ||
						rsp.occupancy !== want.occupancy) begin
						$display("%0t: expected status=%0d id=%h prio=%h occ=%0d", $time,
							want.status, want.out_id, want.out_priority, want.occupancy);
						$display("%0t: actual   status=%0d id=%h prio=%h occ=%0d", $time,
							rsp.status, rsp.out_id, rsp.out_priority, rsp.occupancy);
						errors++;
					end
				end
			end
			if (req_valid && req_ready)
				rsp_due.push_back(serve_request(req));
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("** sorted_priority_queue: FAILED **");
			$finish;
		end
	end

	initial begin
		idle_pct = 25;
		// pops on an empty queue, with junk in the ignored fields
		add_req(CMD_POP, 16'hFFFF, 8'hFF);
		add_req(CMD_POP, 16'h0000, 8'h00);
		// fill to the top with extremes and ties
		add_req(CMD_INSERT, 16'h0000, 8'h00);
		add_req(CMD_INSERT, 16'hFFFF, 8'hFF);
		add_req(CMD_INSERT, 16'hAAAA, 8'h80);
		add_req(CMD_INSERT, 16'h5555, 8'h80);
		add_req(CMD_INSERT, 16'h1234, 8'h80);
		add_req(CMD_INSERT, 16'h0001, 8'h01);
		add_req(CMD_INSERT, 16'h8000, 8'hFE);
		add_req(CMD_INSERT, 16'h7FFF, 8'h7F);
		add_req(CMD_INSERT, 16'h00FF, 8'h00);
		add_req(CMD_INSERT, 16'hFF00, 8'hFF);
		add_req(CMD_INSERT, 16'h0F0F, 8'h80);
		add_req(CMD_INSERT, 16'hF0F0, 8'h81);
		add_req(CMD_INSERT, 16'h3333, 8'h7F);
		add_req(CMD_INSERT, 16'hCCCC, 8'h01);
		add_req(CMD_INSERT, 16'h6666, 8'hFF);
		add_req(CMD_INSERT, 16'h9999, 8'h00);
		// inserts rejected while full, even at top priority, then pops from the front
		add_req(CMD_INSERT, 16'hABCD, 8'hFF);
		add_req(CMD_INSERT, 16'hDCBA, 8'h00);
		add_req(CMD_POP, 16'h5A5A, 8'hA5);
		add_req(CMD_POP, 16'h0000, 8'h00);
		add_req(CMD_POP, 16'hFFFF, 8'hFF);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		@(posedge clk);
		settle();
		idle_pct = 50;
		queue_traffic(420);
		settle();
		idle_pct = 15;
		queue_traffic(420);
		settle();
		idle_pct = 0;
		queue_traffic(420);
		settle();
		repeat (8) @(posedge clk);

		if (errors == 0)
			$display("** sorted_priority_queue: PASSED **");
		else
			$display("** sorted_priority_queue: FAILED **");
		$finish;
	end

endmodule
